/* hdl/ahp_pkg.sv */
// ahp_pkg: shared types and constants for the altitude-hold PID block.
// Holds the field widths, limits, register indexes and the controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ahp_pkg;

	// Field widths
	localparam int unsigned TARGET_W   = 16;
	localparam int unsigned GAIN_W     = 26;
	localparam int unsigned DIST_W     = 16;
	localparam int unsigned STICK_W    = 11;
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned CORR_W     = 12;
	localparam int unsigned THR_W      = 11;

	// Stream and config port widths
	localparam int unsigned S_TDATA_W  = 48;
	localparam int unsigned M_TDATA_W  = 24;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 26;

	// Internal arithmetic widths
	localparam int unsigned ERR_W      = 17;  // target - distance
	localparam int unsigned DIFF_W     = 18;  // err - prev_err
	localparam int unsigned SUM_W      = 32;  // saturating integral
	localparam int unsigned MUL_A_W    = 32;  // largest magnitude operand
	localparam int unsigned PROD_W     = MUL_A_W + GAIN_W;
	localparam int unsigned DVD_W      = 29;  // |diff| * 4000 < 2^29
	localparam int unsigned DVS_W      = 14;  // period <= 10000
	localparam int unsigned DIV_CNT_W  = $clog2(DVD_W);
	localparam int unsigned TERM_W     = 11;  // clamped term magnitude
	localparam int unsigned THR_SUM_W  = 13;  // stick + correction, signed

	// Constants
	localparam int unsigned PERIOD_MAX  = 10000;
	localparam int unsigned DERIV_SCALE = 4000;
	localparam int unsigned P_LIMIT     = 400;
	localparam int unsigned I_LIMIT     = 1000;
	localparam int unsigned D_LIMIT     = 500;
	localparam int unsigned THR_MIN     = 1000;
	localparam int unsigned THR_MAX     = 2000;

	// Register reset values
	localparam logic signed [TARGET_W-1:0] TARGET_RST = 16'sd500;
	localparam logic [GAIN_W-1:0] GAIN_P_RST = 26'd26214;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 26'd66;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 26'd3276800;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_PREP,
		S_SCALE,
		S_DIV_START,
		S_DIV,
		S_MUL_I,
		S_MUL_D,
		S_ACC_D,
		S_OUT
	} ahp_state_t;

	typedef enum logic [1:0] {
		MUL_SCALE,
		MUL_P,
		MUL_I,
		MUL_D
	} ahp_mul_sel_t;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_I,
		TERM_D
	} ahp_term_t;

	typedef struct packed {
		logic         load;       // latch input item
		logic         clear;      // disabled item: clear state, zero correction
		logic         calc_err;   // register target - distance
		logic         prep;       // integral and difference
		logic         mul_en;     // load the product register
		ahp_mul_sel_t mul_sel;
		logic         div_start;
		logic         acc_en;     // add a clamped term into the correction
		ahp_term_t    acc_sel;
		logic         commit;     // write back error_sum and prev_error
		logic         out_load;   // move result into the output register
	} ahp_cmd_t;

	typedef struct packed {
		logic period_ok;
		logic enable;
		logic div_busy;
		logic out_free;
	} ahp_status_t;

endpackage

`default_nettype wire

/* hdl/ahp_div.sv */
// ahp_div: restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on ahp_pkg for the dividend/divisor widths.
`timescale 1ns / 1ps
`default_nettype none

module ahp_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ahp_pkg::DVD_W-1:0]   dividend,
	input  wire logic [ahp_pkg::DVS_W-1:0]   divisor,
	output logic                             busy,
	output logic [ahp_pkg::DVD_W-1:0]        quotient
);

	localparam int unsigned DVD_W = ahp_pkg::DVD_W;
	localparam int unsigned DVS_W = ahp_pkg::DVS_W;
	localparam int unsigned CNT_W = ahp_pkg::DIV_CNT_W;

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DVS_W-1:0]    rem_q;
	logic [DVS_W-1:0]    dvs_q;
	logic [DVD_W-1:0]    quo_q;
	logic [DVS_W:0]      trial;
	logic                fits;
	logic [DVS_W:0]      trial_sub;

	// One restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial     = {rem_q, quo_q[DVD_W-1]};
		fits      = trial >= {1'b0, dvs_q};
		trial_sub = trial - {1'b0, dvs_q};
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	// Partial remainder never reaches the divisor while stepping
	ast_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < dvs_q))
		else $error("divider remainder out of range");

endmodule

`default_nettype wire

/* hdl/ahp_dp.sv */
// ahp_dp: datapath of the altitude-hold PID: config registers, state, shared
// gain multiplier, term clamp/accumulate and output register.
// Depends on ahp_pkg and instantiates ahp_div.
`timescale 1ns / 1ps
`default_nettype none

module ahp_dp #(
	parameter int unsigned GAIN_FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// config writes
	input  wire logic                              cfg_valid,
	input  wire logic [ahp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ahp_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input item fields
	input  wire logic [ahp_pkg::DIST_W-1:0]        in_distance,
	input  wire logic [ahp_pkg::STICK_W-1:0]       in_stick,
	input  wire logic [ahp_pkg::PERIOD_W-1:0]      in_period,
	input  wire logic                              in_enable,
	// controller link
	input  wire ahp_pkg::ahp_cmd_t                 cmd,
	output ahp_pkg::ahp_status_t                   status,
	// result side
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic [ahp_pkg::CORR_W-1:0]             out_correction,
	output logic [ahp_pkg::THR_W-1:0]              out_throttle
);

	localparam int unsigned ERR_W   = ahp_pkg::ERR_W;
	localparam int unsigned DIFF_W  = ahp_pkg::DIFF_W;
	localparam int unsigned SUM_W   = ahp_pkg::SUM_W;
	localparam int unsigned MUL_A_W = ahp_pkg::MUL_A_W;
	localparam int unsigned GAIN_W  = ahp_pkg::GAIN_W;
	localparam int unsigned PROD_W  = ahp_pkg::PROD_W;
	localparam int unsigned DVD_W   = ahp_pkg::DVD_W;
	localparam int unsigned DVS_W   = ahp_pkg::DVS_W;
	localparam int unsigned TERM_W  = ahp_pkg::TERM_W;
	localparam int unsigned CORR_W  = ahp_pkg::CORR_W;
	localparam int unsigned THR_W   = ahp_pkg::THR_W;
	localparam int unsigned TS_W    = ahp_pkg::THR_SUM_W;

	// Configuration registers
	logic signed [ahp_pkg::TARGET_W-1:0] target_q;
	logic [GAIN_W-1:0]                   gain_p_q;
	logic [GAIN_W-1:0]                   gain_i_q;
	logic [GAIN_W-1:0]                   gain_d_q;

	// Controller state carried across items
	logic signed [SUM_W-1:0]             error_sum_q;
	logic signed [ERR_W-1:0]             prev_err_q;

	// Latched input item
	logic signed [ahp_pkg::DIST_W-1:0]   dist_q;
	logic [ahp_pkg::STICK_W-1:0]         stick_q;
	logic [ahp_pkg::PERIOD_W-1:0]        period_q;
	logic                                enable_q;

	// Working registers
	logic signed [ERR_W-1:0]             err_q;
	logic signed [SUM_W-1:0]             sum_q;
	logic [DIFF_W-1:0]                   diff_mag_q;
	logic                                diff_neg_q;
	logic [PROD_W-1:0]                   product_q;
	logic signed [CORR_W-1:0]            corr_q;

	// Output register
	logic                                out_valid_q;
	logic [CORR_W-1:0]                   out_corr_q;
	logic [THR_W-1:0]                    out_thr_q;

	// Combinational signals
	logic signed [SUM_W:0]               sum_wide;
	logic signed [SUM_W-1:0]             sum_sat;
	logic signed [DIFF_W-1:0]            diff;
	logic [ERR_W-1:0]                    err_mag;
	logic [SUM_W-1:0]                    sum_mag;
	logic [MUL_A_W-1:0]                  mul_a;
	logic [GAIN_W-1:0]                   mul_b;
	logic [PROD_W-1:0]                   shifted;
	logic [TERM_W-1:0]                   limit;
	logic                                term_neg;
	logic [TERM_W-1:0]                   term_mag;
	logic signed [CORR_W-1:0]            term_pos;
	logic signed [CORR_W-1:0]            term;
	logic signed [TS_W-1:0]              thr_sum;
	logic [THR_W-1:0]                    thr_clamped;
	logic                                div_busy;
	logic [DVD_W-1:0]                    quotient;

	// Config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= ahp_pkg::TARGET_RST;
			gain_p_q <= ahp_pkg::GAIN_P_RST;
			gain_i_q <= ahp_pkg::GAIN_I_RST;
			gain_d_q <= ahp_pkg::GAIN_D_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ahp_pkg::REG_TARGET: target_q <= cfg_data[ahp_pkg::TARGET_W-1:0];
				ahp_pkg::REG_GAIN_P: gain_p_q <= cfg_data[GAIN_W-1:0];
				ahp_pkg::REG_GAIN_I: gain_i_q <= cfg_data[GAIN_W-1:0];
				ahp_pkg::REG_GAIN_D: gain_d_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturating integral and error difference
	always_comb begin
		sum_wide = {error_sum_q[SUM_W-1], error_sum_q}
			+ {{(SUM_W + 1 - ERR_W){err_q[ERR_W-1]}}, err_q};
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
				: {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
		diff = {err_q[ERR_W-1], err_q} - {prev_err_q[ERR_W-1], prev_err_q};
		err_mag = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
		sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	end

	// Shared multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			ahp_pkg::MUL_SCALE: begin
				mul_a = MUL_A_W'(diff_mag_q);
				mul_b = GAIN_W'(ahp_pkg::DERIV_SCALE);
			end
			ahp_pkg::MUL_P: begin
				mul_a = MUL_A_W'(err_mag);
				mul_b = gain_p_q;
			end
			ahp_pkg::MUL_I: begin
				mul_a = sum_mag;
				mul_b = gain_i_q;
			end
			ahp_pkg::MUL_D: begin
				mul_a = MUL_A_W'(quotient);
				mul_b = gain_d_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Scale, clamp and sign the term in the product register
	always_comb begin
		shifted = product_q >> GAIN_FRAC_BITS;
		case (cmd.acc_sel)
			ahp_pkg::TERM_P: begin
				limit    = TERM_W'(ahp_pkg::P_LIMIT);
				term_neg = err_q[ERR_W-1];
			end
			ahp_pkg::TERM_I: begin
				limit    = TERM_W'(ahp_pkg::I_LIMIT);
				term_neg = sum_q[SUM_W-1];
			end
			ahp_pkg::TERM_D: begin
				limit    = TERM_W'(ahp_pkg::D_LIMIT);
				term_neg = diff_neg_q;
			end
			default: begin
				limit    = '0;
				term_neg = 1'b0;
			end
		endcase
		term_mag = (shifted > PROD_W'(limit)) ? limit : shifted[TERM_W-1:0];
		term_pos = {1'b0, term_mag};
		term     = term_neg ? -term_pos : term_pos;
	end

	// Throttle plus correction, clamped
	always_comb begin
		thr_sum = $signed({{(TS_W - THR_W){1'b0}}, stick_q})
			+ {{(TS_W - CORR_W){corr_q[CORR_W-1]}}, corr_q};
		if (thr_sum < $signed(TS_W'(ahp_pkg::THR_MIN))) begin
			thr_clamped = THR_W'(ahp_pkg::THR_MIN);
		end else if (thr_sum > $signed(TS_W'(ahp_pkg::THR_MAX))) begin
			thr_clamped = THR_W'(ahp_pkg::THR_MAX);
		end else begin
			thr_clamped = thr_sum[THR_W-1:0];
		end
	end

	// Item state: integral and last error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else if (cmd.clear) begin
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else if (cmd.commit) begin
			error_sum_q <= sum_q;
			prev_err_q  <= err_q;
		end
	end

	// Input latch and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dist_q   <= in_distance;
			stick_q  <= in_stick;
			period_q <= in_period;
			enable_q <= in_enable;
		end
		if (cmd.calc_err) begin
			err_q <= {target_q[ahp_pkg::TARGET_W-1], target_q}
				- {dist_q[ahp_pkg::DIST_W-1], dist_q};
		end
		if (cmd.prep) begin
			sum_q      <= sum_sat;
			diff_neg_q <= diff[DIFF_W-1];
			diff_mag_q <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		end
		if (cmd.mul_en) begin
			product_q <= mul_a * mul_b;
		end
		if (cmd.clear || cmd.prep) begin
			corr_q <= '0;
		end else if (cmd.acc_en) begin
			corr_q <= corr_q + term;
		end
	end

	// Derivative divider: |diff| * 4000 / period
	ahp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (product_q[DVD_W-1:0]),
		.divisor  (period_q[DVS_W-1:0]),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_corr_q <= corr_q;
			out_thr_q  <= thr_clamped;
		end
	end

	// Status to controller
	always_comb begin
		status.period_ok = (period_q != '0)
			&& (period_q <= ahp_pkg::PERIOD_W'(ahp_pkg::PERIOD_MAX));
		status.enable    = enable_q;
		status.div_busy  = div_busy;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid      = out_valid_q;
	assign out_correction = out_corr_q;
	assign out_throttle   = out_thr_q;

	// Correction stays within the sum of the three term limits
	ast_corr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($signed(out_corr_q) >= -12'sd1900)
			&& ($signed(out_corr_q) <= 12'sd1900))
		else $error("correction out of range");

	// Throttle output always inside the clamp window
	ast_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_thr_q >= THR_W'(ahp_pkg::THR_MIN))
			&& (out_thr_q <= THR_W'(ahp_pkg::THR_MAX)))
		else $error("throttle out of range");

endmodule

`default_nettype wire

/* hdl/ahp_ctrl.sv */
// ahp_ctrl: sequencer of the altitude-hold PID; issues datapath commands
// step by step for each item. Depends on ahp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ahp_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire ahp_pkg::ahp_status_t  status,
	output ahp_pkg::ahp_cmd_t          cmd
);

	ahp_pkg::ahp_state_t state_q;
	ahp_pkg::ahp_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ahp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ahp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ahp_pkg::S_CHECK;
				end
			end
			ahp_pkg::S_CHECK: begin
				if (!status.period_ok) begin
					state_d = ahp_pkg::S_IDLE;
				end else if (!status.enable) begin
					cmd.clear = 1'b1;
					state_d   = ahp_pkg::S_OUT;
				end else begin
					cmd.calc_err = 1'b1;
					state_d      = ahp_pkg::S_PREP;
				end
			end
			ahp_pkg::S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ahp_pkg::S_SCALE;
			end
			ahp_pkg::S_SCALE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ahp_pkg::MUL_SCALE;
				state_d     = ahp_pkg::S_DIV_START;
			end
			ahp_pkg::S_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ahp_pkg::S_DIV;
			end
			ahp_pkg::S_DIV: begin
				// P product starts as soon as the quotient is final
				if (!status.div_busy) begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = ahp_pkg::MUL_P;
					state_d     = ahp_pkg::S_MUL_I;
				end
			end
			ahp_pkg::S_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ahp_pkg::MUL_I;
				cmd.acc_en  = 1'b1;
				cmd.acc_sel = ahp_pkg::TERM_P;
				state_d     = ahp_pkg::S_MUL_D;
			end
			ahp_pkg::S_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ahp_pkg::MUL_D;
				cmd.acc_en  = 1'b1;
				cmd.acc_sel = ahp_pkg::TERM_I;
				state_d     = ahp_pkg::S_ACC_D;
			end
			ahp_pkg::S_ACC_D: begin
				cmd.acc_en  = 1'b1;
				cmd.acc_sel = ahp_pkg::TERM_D;
				cmd.commit  = 1'b1;
				state_d     = ahp_pkg::S_OUT;
			end
			ahp_pkg::S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ahp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ahp_pkg::S_IDLE;
			end
		endcase
	end

	// A new item never lands on a running division
	ast_accept_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !status.div_busy)
		else $error("item accepted while divider busy");

	// Divider is only started once the scaled difference is in the product register
	ast_div_after_scale: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> $past(cmd.mul_en) && ($past(cmd.mul_sel) == ahp_pkg::MUL_SCALE))
		else $error("divider started without scaled dividend");

	// A result is only loaded when the output register can take it
	ast_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free && !status.div_busy)
		else $error("result loaded into busy output register");

endmodule

`default_nettype wire

/* hdl/altitude_hold_pid.sv */
// altitude_hold_pid: top level of the altitude-hold PID controller.
// Depends on ahp_pkg; instantiates ahp_ctrl and ahp_dp (which holds ahp_div).
//
// Altitude-hold PID with per-term clamping. Each input item carries distance,
// throttle, loop period and an enable flag; it yields one result (correction
// and clamped throttle), or none when the period is 0 or above 10000. The
// block handles one item at a time; an enabled item's time from accept to the
// next possible accept is set mostly by the 29-step bit-serial divider for
// the derivative, plus the shared 32x26 gain multiplier used four times in
// turn. A disabled item skips the arithmetic; one with a bad period is dropped.
// The finished result waits in an output register, so the next
// item is accepted while the previous result is still held on the output.
// Configuration writes are always accepted and must only happen while idle.
`timescale 1ns / 1ps
`default_nettype none

module altitude_hold_pid #(
	parameter int unsigned GAIN_FRAC_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input items
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// [15:0] distance_mm, [26:16] stick_throttle, [42:27] period_us, [47:43] zero
	input  wire logic [ahp_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// [0] hold_enable
	input  wire logic                               s_axis_tuser,
	// result items
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [11:0] correction, [22:12] throttle_out, [23] zero
	output logic [ahp_pkg::M_TDATA_W-1:0]           m_axis_tdata,
	// configuration writes
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ahp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ahp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned DIST_LO   = 0;
	localparam int unsigned STICK_LO  = DIST_LO + ahp_pkg::DIST_W;
	localparam int unsigned PERIOD_LO = STICK_LO + ahp_pkg::STICK_W;
	localparam int unsigned OUT_PAD_W = ahp_pkg::M_TDATA_W - ahp_pkg::CORR_W - ahp_pkg::THR_W;

	ahp_pkg::ahp_cmd_t              cmd;
	ahp_pkg::ahp_status_t           status;
	logic [ahp_pkg::CORR_W-1:0]     correction;
	logic [ahp_pkg::THR_W-1:0]      throttle_out;

	assign cfg_ready = 1'b1;

	// Sequencer
	ahp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath
	ahp_dp #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_distance    (s_axis_tdata[DIST_LO +: ahp_pkg::DIST_W]),
		.in_stick       (s_axis_tdata[STICK_LO +: ahp_pkg::STICK_W]),
		.in_period      (s_axis_tdata[PERIOD_LO +: ahp_pkg::PERIOD_W]),
		.in_enable      (s_axis_tuser),
		.cmd            (cmd),
		.status         (status),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_correction (correction),
		.out_throttle   (throttle_out)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, throttle_out, correction};

endmodule

`default_nettype wire
